[src/ole_pkg.sv]
// Shared types and constants for the ordered list engine.
package ole_pkg;

    localparam int CAPACITY = 32;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    localparam logic [2:0] OP_INS_FRONT = 3'd0;
    localparam logic [2:0] OP_INS_BACK  = 3'd1;
    localparam logic [2:0] OP_DEL_FRONT = 3'd2;
    localparam logic [2:0] OP_DEL_BACK  = 3'd3;
    localparam logic [2:0] OP_DEL_VALUE = 3'd4;
    localparam logic [2:0] OP_LIST      = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] element;
        logic [COUNT_W-1:0] count;
        logic               last;
    } rsp_t;

    // memory write source while walking
    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_UP    = 2'd1,
        WR_DOWN  = 2'd2
    } wr_mode_t;

    typedef struct packed {
        logic       load;
        logic       walk_start;
        logic       walk_from_top;
        logic       walk_en;
        wr_mode_t   wr_mode;
        logic       wr_front;
        logic       wr_back;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       emit_list;
        logic       emit_done;
        logic [1:0] status;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic act;
        logic pend;
        logic match;
    } sts_t;

endpackage

[src/ole_dpath.sv]
// Datapath: element memory, walk pointers, count and result register.
module ole_dpath (
    input  logic          clk,
    input  logic          rst_n,
    input  ole_pkg::cmd_t cmd,
    input  ole_pkg::req_t request,
    output ole_pkg::sts_t sts,
    output logic          done,
    output ole_pkg::rsp_t result
);

    logic signed [31:0] mem [ole_pkg::CAPACITY];

    logic [ole_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [ole_pkg::IDX_W-1:0]   ridx_reg, ridx_next;
    logic [ole_pkg::IDX_W-1:0]   pidx_reg, pidx_next;
    logic                        act_reg, act_next;
    logic                        pend_reg, pend_next;
    logic                        dir_reg, dir_next;
    logic signed [31:0]          value_reg, value_next;
    logic signed [31:0]          rd_data_reg;
    logic                        res_valid_reg, res_valid_next;
    ole_pkg::rsp_t               res_reg, res_next;

    logic [ole_pkg::COUNT_W-1:0] cnt_m1;
    logic [ole_pkg::IDX_W-1:0]   top_idx;
    logic [ole_pkg::IDX_W-1:0]   end_idx;
    logic                        walking;
    logic                        wr_en;
    logic [ole_pkg::IDX_W-1:0]   wr_addr;
    logic signed [31:0]          wr_data;

    always_comb
    begin
        cnt_m1  = count_reg - ole_pkg::COUNT_W'(1);
        top_idx = cnt_m1[ole_pkg::IDX_W-1:0];
        end_idx = dir_reg ? '0 : top_idx;
        walking = cmd.walk_en && act_reg;

        value_next = cmd.load ? request.value : value_reg;

        if (cmd.walk_start)
        begin
            ridx_next = cmd.walk_from_top ? top_idx : '0;
            act_next  = 1'b1;
            dir_next  = cmd.walk_from_top;
        end
        else
        begin
            ridx_next = ridx_reg;
            act_next  = act_reg;
            dir_next  = dir_reg;
            if (walking)
            begin
                ridx_next = dir_reg ? ridx_reg - ole_pkg::IDX_W'(1)
                                    : ridx_reg + ole_pkg::IDX_W'(1);
                act_next  = (ridx_reg != end_idx);
            end
        end

        pend_next = walking;
        pidx_next = walking ? ridx_reg : pidx_reg;

        // one write port: shifts while walking, front/back insert at finish
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = rd_data_reg;
        case (cmd.wr_mode)
            ole_pkg::WR_UP:
            begin
                wr_en   = pend_reg;
                wr_addr = pidx_reg + ole_pkg::IDX_W'(1);
            end
            ole_pkg::WR_DOWN:
            begin
                // the head entry of a removal is dropped, not moved
                wr_en   = pend_reg && (pidx_reg != '0);
                wr_addr = pidx_reg - ole_pkg::IDX_W'(1);
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
        if (cmd.wr_front)
        begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = value_reg;
        end
        else if (cmd.wr_back)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[ole_pkg::IDX_W-1:0];
            wr_data = value_reg;
        end

        count_next = count_reg;
        if (cmd.cnt_inc)
            count_next = count_reg + ole_pkg::COUNT_W'(1);
        else if (cmd.cnt_dec)
            count_next = cnt_m1;

        res_valid_next = cmd.emit_list || cmd.emit_done;
        res_next       = res_reg;
        if (cmd.emit_list)
        begin
            res_next.status  = ole_pkg::ST_OK;
            res_next.element = rd_data_reg;
            res_next.count   = count_reg;
            res_next.last    = !act_reg;
        end
        else if (cmd.emit_done)
        begin
            res_next.status  = cmd.status;
            res_next.element = '0;
            res_next.count   = count_next;
            res_next.last    = 1'b1;
        end

        sts.empty = (count_reg == '0);
        sts.full  = (count_reg >= ole_pkg::COUNT_W'(ole_pkg::CAPACITY));
        sts.act   = act_reg;
        sts.pend  = pend_reg;
        sts.match = pend_reg && (rd_data_reg == value_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            act_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            act_reg       <= act_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg  <= ridx_next;
        pidx_reg  <= pidx_next;
        dir_reg   <= dir_next;
        value_reg <= value_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (walking)
            rd_data_reg <= mem[ridx_reg];
    end

    assign done   = res_valid_reg;
    assign result = res_reg;

endmodule

[src/ole_ctrl.sv]
// Controller: operation sequencing state machine.
module ole_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [2:0]    operation,
    input  ole_pkg::sts_t sts,
    output logic          busy,
    output ole_pkg::cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_INS_UP = 6'b000010,
        S_SEARCH = 6'b000100,
        S_SHIFT  = 6'b001000,
        S_LIST   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        A_NONE  = 2'd0,
        A_FRONT = 2'd1,
        A_BACK  = 2'd2,
        A_DEC   = 2'd3
    } action_t;

    state_t     state_reg, state_next;
    action_t    action_reg, action_next;
    logic [1:0] status_reg, status_next;

    always_comb
    begin
        state_next  = state_reg;
        action_next = action_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.wr_mode = ole_pkg::WR_NONE;
        cmd.status  = status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load    = 1'b1;
                    state_next  = S_FINISH;
                    action_next = A_NONE;
                    status_next = ole_pkg::ST_OK;
                    case (operation)
                        ole_pkg::OP_INS_FRONT:
                        begin
                            if (sts.full)
                                status_next = ole_pkg::ST_FULL;
                            else if (sts.empty)
                                action_next = A_FRONT;
                            else
                            begin
                                cmd.walk_start    = 1'b1;
                                cmd.walk_from_top = 1'b1;
                                state_next        = S_INS_UP;
                            end
                        end
                        ole_pkg::OP_INS_BACK:
                        begin
                            if (sts.full)
                                status_next = ole_pkg::ST_FULL;
                            else
                                action_next = A_BACK;
                        end
                        ole_pkg::OP_DEL_FRONT:
                        begin
                            if (sts.empty)
                                status_next = ole_pkg::ST_EMPTY;
                            else
                            begin
                                cmd.walk_start = 1'b1;
                                state_next     = S_SHIFT;
                            end
                        end
                        ole_pkg::OP_DEL_BACK:
                        begin
                            if (sts.empty)
                                status_next = ole_pkg::ST_EMPTY;
                            else
                                action_next = A_DEC;
                        end
                        ole_pkg::OP_DEL_VALUE:
                        begin
                            if (sts.empty)
                                status_next = ole_pkg::ST_EMPTY;
                            else
                            begin
                                cmd.walk_start = 1'b1;
                                state_next     = S_SEARCH;
                            end
                        end
                        ole_pkg::OP_LIST:
                        begin
                            if (sts.empty)
                                status_next = ole_pkg::ST_EMPTY;
                            else
                            begin
                                cmd.walk_start = 1'b1;
                                state_next     = S_LIST;
                            end
                        end
                        default:
                        begin
                            status_next = ole_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_INS_UP:
            begin
                cmd.walk_en = 1'b1;
                cmd.wr_mode = ole_pkg::WR_UP;
                if (sts.pend && !sts.act)
                begin
                    action_next = A_FRONT;
                    state_next  = S_FINISH;
                end
            end
            S_SEARCH:
            begin
                cmd.walk_en = 1'b1;
                if (sts.match)
                    state_next = S_SHIFT;   // reads already in flight feed the shift
                else if (sts.pend && !sts.act)
                begin
                    status_next = ole_pkg::ST_NOT_FOUND;
                    state_next  = S_FINISH;
                end
            end
            S_SHIFT:
            begin
                cmd.walk_en = 1'b1;
                cmd.wr_mode = ole_pkg::WR_DOWN;
                if (!sts.pend && !sts.act)
                begin
                    action_next = A_DEC;
                    state_next  = S_FINISH;
                end
            end
            S_LIST:
            begin
                cmd.walk_en   = 1'b1;
                cmd.emit_list = sts.pend;
                if (sts.pend && !sts.act)
                    state_next = S_IDLE;
            end
            S_FINISH:
            begin
                cmd.emit_done = 1'b1;
                case (action_reg)
                    A_FRONT:
                    begin
                        cmd.wr_front = 1'b1;
                        cmd.cnt_inc  = 1'b1;
                    end
                    A_BACK:
                    begin
                        cmd.wr_back = 1'b1;
                        cmd.cnt_inc = 1'b1;
                    end
                    A_DEC:
                    begin
                        cmd.cnt_dec = 1'b1;
                    end
                    default:
                    begin
                        cmd.cnt_inc = 1'b0;
                    end
                endcase
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            action_reg <= A_NONE;
            status_reg <= ole_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            action_reg <= action_next;
            status_reg <= status_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[src/ordered_list_engine_unit.sv]
// Top level of the ordered list engine: controller plus datapath.
//
// Bounded ordered list of signed 32-bit values (up to ole_pkg::CAPACITY).
// Request channel: a request (operation, value) is taken at a rising edge
// where start is high and busy is low; busy stays high until the last
// result of that request has been registered.
// Result channel: each result is on the result port for one cycle with
// done high. List gives one result per element, front first, with last set
// on the final one (an empty list gives one result with status empty);
// every other request gives one result.
// Insert back, delete back and the full, empty and unknown cases go straight
// to the finish state; insert front, delete front, delete value and list
// first walk the stored elements, and list results follow one per cycle.
// A walk moves one entry per cycle through a registered read port and a
// separate write port, so the longest request is delete front or delete
// value on a full list.
// A new request can be taken in the cycle the last result is shown; the
// receiver cannot stall. Reset clears the count and control state only;
// the memory is not cleared and only entries below the count are read.
module ordered_list_engine_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  ole_pkg::req_t request,
    output logic          done,
    output ole_pkg::rsp_t result
);

    ole_pkg::cmd_t cmd;
    ole_pkg::sts_t sts;

    ole_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (request.operation),
        .sts       (sts),
        .busy      (busy),
        .cmd       (cmd)
    );

    ole_dpath u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .sts     (sts),
        .done    (done),
        .result  (result)
    );

endmodule

[src/ole_checker.sv]
// Port-level checks for the ordered list engine, bound to the top level.
module ole_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input ole_pkg::rsp_t result
);

    // final result of a request frees the engine
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.last |-> !busy)
        else $error("engine busy at final result");

    // mid-list results only while the engine is still working
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.last |-> busy)
        else $error("non-final result while idle");

    // every accepted request makes the engine busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but engine not busy");

    // a failure status always ends its request
    a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ole_pkg::ST_OK |-> result.last)
        else $error("failure status on non-final result");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.count <= ole_pkg::COUNT_W'(ole_pkg::CAPACITY))
        else $error("count above capacity");

endmodule

bind ordered_list_engine_unit ole_checker u_ole_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .result  (result)
);
